// File: rtl/persistent_lattice_walk_step_core_defines.svh
// assertion macros shared by the walker core
`ifndef PERSISTENT_LATTICE_WALK_STEP_CORE_DEFINES_SVH
`define PERSISTENT_LATTICE_WALK_STEP_CORE_DEFINES_SVH

// ante holds at a clock edge, cons must hold at the next one
`define PLWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// ante and cons at the same clock edge
`define PLWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/plws_pkg.sv
// types, codes and helpers of the lattice walker core
`default_nettype none

package plws_pkg;

    localparam int unsigned STEP_LENGTH_DEF = 1;
    localparam int unsigned RAND_BITS       = 16;

    localparam int unsigned RAND_W      = 16;
    localparam int unsigned POS_W       = 12;
    localparam int unsigned DIR_W       = 3;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned THR_W       = 17;
    localparam int unsigned LEN_W       = 11;
    localparam int unsigned TGT_W       = 10;
    localparam int unsigned DIST_W      = 11;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 17;
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 96;

    // random fractions only carry RAND_BITS significant bits
    localparam logic [RAND_W-1:0] RAND_MASK = (RAND_BITS >= RAND_W) ? {RAND_W{1'b1}} :
                                              RAND_W'((64'd1 << RAND_BITS) - 64'd1);

    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATTICE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSORB   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT   = 3'd7;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [1:0] MODE_ABSORB   = 2'd2;
    localparam logic [1:0] MODE_LATERAL  = 2'd3;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

    localparam logic OP_PLACE = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0]  straight_thr;
        logic [THR_W-1:0]  back_thr;
        logic [LEN_W-1:0]  lattice_size;
        logic [1:0]        mode;
        logic [THR_W-1:0]  absorb_thr;
        logic [TGT_W-1:0]  target_x;
        logic [TGT_W-1:0]  target_y;
        logic [DIST_W-1:0] detect_dist;
    } t_cfg;

    typedef struct packed {
        logic              op;
        logic [RAND_W-1:0] rand_dir;
        logic              rand_turn;
        logic [RAND_W-1:0] rand_absorb;
        logic [TGT_W-1:0]  place_x;
        logic [TGT_W-1:0]  place_y;
        logic [DIR_W-1:0]  place_dir;
    } t_item;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [DIR_W-1:0]        dir;
        logic [CNT_W-1:0]        refl;
        logic [CNT_W-1:0]        absorbed;
    } t_walk;

    // fold any code into 1..4, only the low two bits matter
    function automatic logic [DIR_W-1:0] norm_dir(input logic [DIR_W-1:0] d);
        logic [1:0] t;
        t = d[1:0] + 2'd3;
        return {1'b0, t} + 3'd1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/plws_step.sv
// next walker state for one item: placing, heading choice, move, wrap and walls
`default_nettype none

module plws_step #(
    parameter int unsigned STEP_LENGTH = plws_pkg::STEP_LENGTH_DEF
) (
    input  plws_pkg::t_cfg  i_cfg,
    input  plws_pkg::t_item i_item,
    input  plws_pkg::t_walk i_cur,
    output plws_pkg::t_walk o_nxt
);
    import plws_pkg::*;

    localparam logic signed [POS_W-1:0] STEP = POS_W'(STEP_LENGTH);

    function automatic logic signed [POS_W-1:0] wrap_axis(
        input logic signed [POS_W-1:0] v,
        input logic [LEN_W-1:0]        len
    );
        logic [POS_W-1:0] vu;
        logic [POS_W-1:0] lu;
        vu = v;
        lu = {1'b0, len};
        if (v[POS_W-1]) begin
            return $signed(vu + lu);
        end else if (vu >= lu) begin
            return $signed(vu - lu);
        end
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 32'd1;
    endfunction

    logic [RAND_W-1:0]       dir_frac;
    logic [RAND_W-1:0]       abs_frac;
    logic                    go_turn;
    logic                    go_back;
    logic [DIR_W-1:0]        mv_dir;
    logic signed [POS_W-1:0] mv_x;
    logic signed [POS_W-1:0] mv_y;
    logic [POS_W:0]          wall_hi;
    logic                    on_wall;
    logic                    reflect;
    logic signed [POS_W-1:0] wall_x;
    logic signed [POS_W-1:0] wall_y;
    logic [DIR_W-1:0]        wall_dir;

    // heading choice and free move
    always_comb begin
        dir_frac = i_item.rand_dir & RAND_MASK;
        go_turn  = {1'b0, dir_frac} >= i_cfg.back_thr;
        go_back  = {1'b0, dir_frac} >= i_cfg.straight_thr;
        if (go_turn) begin
            mv_dir = norm_dir(i_item.rand_turn ? i_cur.dir - 3'd1 : i_cur.dir + 3'd1);
        end else if (go_back) begin
            mv_dir = norm_dir(i_cur.dir + 3'd2);
        end else begin
            mv_dir = i_cur.dir;
        end
        mv_x = i_cur.x;
        mv_y = i_cur.y;
        case (mv_dir)
            DIR_RIGHT: begin
                mv_x = i_cur.x + STEP;
            end
            DIR_UP: begin
                mv_y = i_cur.y + STEP;
            end
            DIR_LEFT: begin
                mv_x = i_cur.x - STEP;
            end
            default: begin
                mv_y = i_cur.y - STEP;
            end
        endcase
    end

    // wall tests in priority order, lattice size may be below two
    always_comb begin
        abs_frac = i_item.rand_absorb & RAND_MASK;
        reflect  = {1'b0, abs_frac} <= i_cfg.absorb_thr;
        wall_hi  = {2'b00, i_cfg.lattice_size} - 13'd1;
        on_wall  = 1'b1;
        wall_x   = i_cur.x;
        wall_y   = i_cur.y;
        wall_dir = i_cur.dir;
        if (i_cur.x == '0) begin
            wall_x   = i_cur.x + STEP;
            wall_dir = DIR_RIGHT;
        end else if ({i_cur.x[POS_W-1], i_cur.x} == wall_hi) begin
            wall_x   = i_cur.x - STEP;
            wall_dir = DIR_LEFT;
        end else if (i_cur.y == '0) begin
            wall_y   = i_cur.y + STEP;
            wall_dir = DIR_UP;
        end else if ({i_cur.y[POS_W-1], i_cur.y} == wall_hi) begin
            wall_y   = i_cur.y - STEP;
            wall_dir = DIR_DOWN;
        end else begin
            on_wall = 1'b0;
        end
    end

    always_comb begin
        o_nxt = i_cur;
        if (i_item.op == OP_PLACE) begin
            o_nxt.x   = $signed({2'b00, i_item.place_x});
            o_nxt.y   = $signed({2'b00, i_item.place_y});
            o_nxt.dir = norm_dir(i_item.place_dir);
        end else begin
            case (i_cfg.mode)
                MODE_PERIODIC: begin
                    o_nxt.x   = wrap_axis(mv_x, i_cfg.lattice_size);
                    o_nxt.y   = wrap_axis(mv_y, i_cfg.lattice_size);
                    o_nxt.dir = mv_dir;
                end
                MODE_ABSORB: begin
                    if (!on_wall) begin
                        o_nxt.x   = mv_x;
                        o_nxt.y   = mv_y;
                        o_nxt.dir = mv_dir;
                    end else if (reflect) begin
                        o_nxt.x    = wall_x;
                        o_nxt.y    = wall_y;
                        o_nxt.dir  = wall_dir;
                        o_nxt.refl = sat_inc(i_cur.refl);
                    end else begin
                        o_nxt.absorbed = sat_inc(i_cur.absorbed);
                    end
                end
                MODE_NONE, MODE_LATERAL: begin
                    o_nxt = i_cur;
                end
                default: begin
                    o_nxt = i_cur;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/plws_detect.sv
// manhattan distance test between walker and target
`default_nettype none

module plws_detect (
    input  logic signed [plws_pkg::POS_W-1:0] i_x,
    input  logic signed [plws_pkg::POS_W-1:0] i_y,
    input  logic [plws_pkg::TGT_W-1:0]        i_target_x,
    input  logic [plws_pkg::TGT_W-1:0]        i_target_y,
    input  logic [plws_pkg::DIST_W-1:0]       i_detect_dist,
    output logic                              o_found
);
    import plws_pkg::*;

    logic [POS_W:0] dx;
    logic [POS_W:0] dy;
    logic [POS_W:0] ax;
    logic [POS_W:0] ay;
    logic [POS_W:0] man_dist;

    // |dx| stays below 3072 and the sum below 6144, so 13 bits hold both
    always_comb begin
        dx       = {i_x[POS_W-1], i_x} - {3'b000, i_target_x};
        dy       = {i_y[POS_W-1], i_y} - {3'b000, i_target_y};
        ax       = dx[POS_W] ? 13'd0 - dx : dx;
        ay       = dy[POS_W] ? 13'd0 - dy : dy;
        man_dist = {1'b0, ax[POS_W-1:0]} + {1'b0, ay[POS_W-1:0]};
        o_found  = man_dist <= {2'b00, i_detect_dist};
    end

endmodule

`default_nettype wire

// File: rtl/persistent_lattice_walk_step_core.sv
// top level of the persistent lattice walker step core
//
// one walker on a square lattice, advanced by one step or place item at a time
// input stream: tuser carries op, tdata the random fractions and place fields
// output stream: one result item per input item, in order, with position,
// heading, target flag and the two saturating wall counters
// config port: write enable, register index and data, taken at any edge
// with the enable high; write only while no item is in flight
// latency: an item accepted at edge n has its result valid after edge n+1,
// taken at edge n+2 at the earliest (input stage, then the state/result register)
// throughput: one item per cycle; the walker update is one combinational pass
// from the input stage into the state register, which doubles as the result
// the target flag is formed from the result register and the config
// reset clears the walker to (0,0) facing right, zeroes the counters, loads
// the config defaults and empties both stages
// a stalled receiver holds the result; the input stage still takes one more
// item, then tready drops until the result is taken
`default_nettype none
`include "persistent_lattice_walk_step_core_defines.svh"

module persistent_lattice_walk_step_core #(
    parameter int unsigned STEP_LENGTH = plws_pkg::STEP_LENGTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [plws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [plws_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // rand_direction, rand_turn, rand_absorb, place_x, place_y, place_dir
    input  logic [plws_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // op
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // pos_x, pos_y, heading, target_found, wall_hits, absorbed_steps, zero pad
    output logic [plws_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import plws_pkg::*;

    t_cfg  r_cfg;
    t_item r_item;
    t_walk r_walk;
    t_walk n_walk;
    t_item in_item;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  advance;
    logic  in_acc;
    logic  found;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        in_item.op          = i_s_axis_tuser;
        in_item.rand_dir    = i_s_axis_tdata[15:0];
        in_item.rand_turn   = i_s_axis_tdata[16];
        in_item.rand_absorb = i_s_axis_tdata[32:17];
        in_item.place_x     = i_s_axis_tdata[42:33];
        in_item.place_y     = i_s_axis_tdata[52:43];
        in_item.place_dir   = i_s_axis_tdata[55:53];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.straight_thr <= 17'd65536;
            r_cfg.back_thr     <= 17'd65536;
            r_cfg.lattice_size <= 11'd64;
            r_cfg.mode         <= MODE_PERIODIC;
            r_cfg.absorb_thr   <= 17'd65536;
            r_cfg.target_x     <= '0;
            r_cfg.target_y     <= '0;
            r_cfg.detect_dist  <= '0;
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_walk.x           <= '0;
            r_walk.y           <= '0;
            r_walk.dir         <= DIR_RIGHT;
            r_walk.refl        <= '0;
            r_walk.absorbed    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STRAIGHT: begin
                        r_cfg.straight_thr <= i_cfg_data;
                    end
                    CFG_BACK: begin
                        r_cfg.back_thr <= i_cfg_data;
                    end
                    CFG_LATTICE: begin
                        r_cfg.lattice_size <= i_cfg_data[LEN_W-1:0];
                    end
                    CFG_MODE: begin
                        r_cfg.mode <= i_cfg_data[1:0];
                    end
                    CFG_ABSORB: begin
                        r_cfg.absorb_thr <= i_cfg_data;
                    end
                    CFG_TARGET_X: begin
                        r_cfg.target_x <= i_cfg_data[TGT_W-1:0];
                    end
                    CFG_TARGET_Y: begin
                        r_cfg.target_y <= i_cfg_data[TGT_W-1:0];
                    end
                    CFG_DETECT: begin
                        r_cfg.detect_dist <= i_cfg_data[DIST_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            // the walker state is the result register
            if (r_in_valid && advance) begin
                r_walk <= n_walk;
            end
        end
    end

    plws_step #(
        .STEP_LENGTH(STEP_LENGTH)
    ) u_step (
        .i_cfg  (r_cfg),
        .i_item (r_item),
        .i_cur  (r_walk),
        .o_nxt  (n_walk)
    );

    plws_detect u_detect (
        .i_x           (r_walk.x),
        .i_y           (r_walk.y),
        .i_target_x    (r_cfg.target_x),
        .i_target_y    (r_cfg.target_y),
        .i_detect_dist (r_cfg.detect_dist),
        .o_found       (found)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_walk.absorbed, r_walk.refl, found, r_walk.dir,
                              r_walk.y, r_walk.x};

    `PLWS_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, in_acc, r_in_valid, "accepted item lost")
    `PLWS_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, r_in_valid && advance, r_out_valid, "result lost")
    `PLWS_ASSERT_NEXT(a_place_counts, i_clk, i_rst_n, r_in_valid && advance && r_item.op == OP_PLACE, $stable(r_walk.refl) && $stable(r_walk.absorbed), "place item changed counters")
    `PLWS_ASSERT_SAME(a_heading_ok, i_clk, i_rst_n, r_out_valid, r_walk.dir >= DIR_RIGHT && r_walk.dir <= DIR_DOWN, "heading out of range")

endmodule

`default_nettype wire
